[hw/rtl/okv_pkg.sv]
// Shared package for the ordered key/value table.
// Holds request and status codes, fixed field widths and the cell control struct.
// Has no dependencies.
package okv_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int REQ_BITS    = 3;
  localparam int INDEX_BITS  = 4;
  localparam int STATUS_BITS = 2;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_INSERT = 3'd0,
    REQ_UPDATE = 3'd1,
    REQ_UPSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_LOOKUP = 3'd4,
    REQ_READ   = 3'd5
  } okv_req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_KEY   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } okv_status_t;

  typedef struct packed {
    logic upd;
    logic app;
    logic shift;
    logic use_idx;
  } okv_ctrl_t;

endpackage

[hw/rtl/okv_cell.sv]
// One storage cell of the ordered key/value table: a key/value pair at a fixed position.
// Compares against the broadcast key and takes data from its right-hand neighbor on erase.
// Depends on okv_pkg.
module okv_cell #(
  parameter int ENTRIES    = okv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = okv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okv_pkg::VALUE_BITS_DEF,
  parameter int POS        = 0
) (
  input  logic                           clk,
  input  okv_pkg::okv_ctrl_t             ctrl,
  input  logic [$clog2(ENTRIES)-1:0]     pos,
  input  logic [$clog2(ENTRIES+1)-1:0]   entry_count,
  input  logic [KEY_BITS-1:0]            key_in,
  input  logic [VALUE_BITS-1:0]          value_in,
  input  logic [KEY_BITS-1:0]            nb_key,
  input  logic [VALUE_BITS-1:0]          nb_value,
  output logic [KEY_BITS-1:0]            stored_key,
  output logic [VALUE_BITS-1:0]          stored_value,
  output logic                           hit,
  output logic                           pick
);
  import okv_pkg::*;

  localparam int PW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [PW-1:0] POS_P = PW'(POS);
  localparam logic [CW-1:0] POS_C = CW'(POS);

  logic valid;

  assign valid = POS_C < entry_count;
  assign hit   = valid && (stored_key == key_in);
  assign pick  = ctrl.use_idx ? (POS_P == pos) : hit;

  always_ff @(posedge clk) begin
    if (ctrl.app && (POS_C == entry_count)) begin
      stored_key   <= key_in;
      stored_value <= value_in;
    end else if (ctrl.shift && (POS_P >= pos)) begin
      stored_key   <= nb_key;
      stored_value <= nb_value;
    end else if (ctrl.upd && hit) begin
      stored_value <= value_in;
    end
  end

endmodule

[hw/rtl/ordered_key_value_table_top.sv]
// Top level of the ordered key/value table: request register, row of cells, result register.
// Depends on okv_pkg and okv_cell.
// A request is held in the request register; its result is registered once the output
// is not stalled. No new request is taken while one is held; the cell row does one
// compare-and-write per request. Reset (synchronous, active high) empties the table and
// clears the request and result valid flags; no clearing pass is needed.
module ordered_key_value_table_top #(
  parameter int ENTRIES    = okv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = okv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okv_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [okv_pkg::REQ_BITS-1:0]      req_type,
  input  logic [KEY_BITS-1:0]               key,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic [okv_pkg::INDEX_BITS-1:0]    index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [okv_pkg::STATUS_BITS-1:0]   status,
  output logic [KEY_BITS-1:0]               key_out,
  output logic [VALUE_BITS-1:0]             value_out,
  output logic [$clog2(ENTRIES+1)-1:0]      count
);
  import okv_pkg::*;

  localparam int PW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = CW + INDEX_BITS;

  logic                   busy;
  logic [REQ_BITS-1:0]    r_type;
  logic [KEY_BITS-1:0]    r_key;
  logic [VALUE_BITS-1:0]  r_value;
  logic [INDEX_BITS-1:0]  r_index;
  logic [CW-1:0]          entry_count;
  logic [CW-1:0]          entry_count_next;

  logic [KEY_BITS-1:0]    cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0]  cell_value [ENTRIES];
  logic [ENTRIES-1:0]     hit_vec;
  logic [ENTRIES-1:0]     pick_vec;

  okv_ctrl_t              ctrl;
  logic [PW-1:0]          hit_pos;
  logic [PW-1:0]          pos;
  logic                   fire;
  logic                   found;
  logic                   full;
  logic                   in_range;
  logic [KEY_BITS-1:0]    pick_key;
  logic [VALUE_BITS-1:0]  pick_value;
  okv_status_t            status_next;
  logic [KEY_BITS-1:0]    key_out_next;
  logic [VALUE_BITS-1:0]  value_out_next;

  assign in_stall = busy;
  assign fire     = busy && (!out_valid || !out_stall);
  assign found    = |hit_vec;
  assign full     = entry_count == CW'(ENTRIES);
  assign in_range = CMPW'(r_index) < CMPW'(entry_count);

  always_comb begin
    hit_pos    = '0;
    pick_key   = '0;
    pick_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_pos    = hit_pos | (hit_vec[i] ? PW'(i) : PW'(0));
      pick_key   = pick_key | (cell_key[i] & {KEY_BITS{pick_vec[i]}});
      pick_value = pick_value | (cell_value[i] & {VALUE_BITS{pick_vec[i]}});
    end
  end

  always_comb begin
    ctrl             = '0;
    pos              = hit_pos;
    status_next      = ST_OK;
    key_out_next     = '0;
    value_out_next   = '0;
    entry_count_next = entry_count;
    case (r_type)
      REQ_INSERT, REQ_UPSERT: begin
        if (found && (r_type == REQ_UPSERT)) begin
          ctrl.upd       = fire;
          key_out_next   = r_key;
          value_out_next = r_value;
        end else if (found) begin
          status_next    = ST_KEY;
          key_out_next   = pick_key;
          value_out_next = pick_value;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.app         = fire;
          key_out_next     = r_key;
          value_out_next   = r_value;
          entry_count_next = entry_count + CW'(1);
        end
      end
      REQ_UPDATE: begin
        if (found) begin
          ctrl.upd       = fire;
          key_out_next   = r_key;
          value_out_next = r_value;
        end else begin
          status_next = ST_KEY;
        end
      end
      REQ_ERASE: begin
        if (found) begin
          ctrl.shift       = fire;
          key_out_next     = pick_key;
          value_out_next   = pick_value;
          entry_count_next = entry_count - CW'(1);
        end else begin
          status_next = ST_KEY;
        end
      end
      REQ_LOOKUP: begin
        if (found) begin
          key_out_next   = pick_key;
          value_out_next = pick_value;
        end else begin
          status_next = ST_KEY;
        end
      end
      REQ_READ: begin
        ctrl.use_idx = 1'b1;
        pos          = PW'(r_index);
        if (in_range) begin
          key_out_next   = pick_key;
          value_out_next = pick_value;
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0]   nb_key;
    logic [VALUE_BITS-1:0] nb_value;

    if (g == ENTRIES - 1) begin : g_last
      assign nb_key   = '0;
      assign nb_value = '0;
    end else begin : g_mid
      assign nb_key   = cell_key[g+1];
      assign nb_value = cell_value[g+1];
    end

    okv_cell #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .POS        (g)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .pos          (pos),
      .entry_count  (entry_count),
      .key_in       (r_key),
      .value_in     (r_value),
      .nb_key       (nb_key),
      .nb_value     (nb_value),
      .stored_key   (cell_key[g]),
      .stored_value (cell_value[g]),
      .hit          (hit_vec[g]),
      .pick         (pick_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        busy    <= 1'b1;
        r_type  <= req_type;
        r_key   <= key;
        r_value <= value;
        r_index <= index;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        out_valid   <= 1'b1;
        status      <= status_next;
        key_out     <= key_out_next;
        value_out   <= value_out_next;
        count       <= entry_count_next;
        entry_count <= entry_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(ENTRIES))
    else $error("Entry count exceeds table size.");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(hit_vec))
    else $error("More than one cell matches the request key.");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.app |=> entry_count == $past(entry_count) + CW'(1))
    else $error("Append did not advance the entry count.");

  a_erase_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |=> entry_count == $past(entry_count) - CW'(1))
    else $error("Erase did not reduce the entry count.");

endmodule
